/* design/vfsp_pkg.sv */
// Shared types, codes and helpers of the tagged-field byte stream parser.
// Used by vfsp_parser, vfsp_result_fifo and varint_field_stream_parser.
package vfsp_pkg;

	localparam int LENGTH_BITS = 32;
	localparam int MAX_GROUPS  = 10;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [2:0] WT_VARINT = 3'd0;
	localparam logic [2:0] WT_LEN    = 3'd2;

	typedef enum logic [2:0] {
		PH_TAG    = 3'd0,
		PH_VALUE  = 3'd1,
		PH_LENGTH = 3'd2,
		PH_BODY   = 3'd3,
		PH_DROP   = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		KIND_INT    = 2'd0,
		KIND_HEADER = 2'd1,
		KIND_BYTE   = 2'd2,
		KIND_ERROR  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE          = 3'd0,
		ERR_VARINT_LONG   = 3'd1,
		ERR_VARINT_TRUNC  = 3'd2,
		ERR_STRING_TRUNC  = 3'd3,
		ERR_BAD_TYPE      = 3'd4,
		ERR_LENGTH_BIG    = 3'd5
	} err_t;

	typedef struct packed {
		kind_t       kind;
		logic [4:0]  field_id;
		logic [2:0]  wire_type;
		logic [63:0] raw_value;
		logic [63:0] zigzag_value;
		logic [31:0] string_length;
		logic [7:0]  body_byte;
		logic        body_last;
		err_t        error_code;
		logic        last_of_run;
	} result_t;

	// Results of one byte, handed from the parser to the result queue.
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

	function automatic result_t make_result(kind_t k, logic [4:0] fld, logic [2:0] wt,
			logic [63:0] raw, logic [31:0] len, logic [7:0] b, logic last, err_t e);
		result_t r;
		r.kind          = k;
		r.field_id      = fld;
		r.wire_type     = wt;
		r.raw_value     = raw;
		r.zigzag_value  = (raw >> 1) ^ {64{raw[0]}};
		r.string_length = len;
		r.body_byte     = b;
		r.body_last     = last;
		r.error_code    = e;
		r.last_of_run   = 1'b0;
		return r;
	endfunction

endpackage

/* design/vfsp_parser.sv */
// Input register and single-pass parse step of the field stream parser.
// Depends on vfsp_pkg; produces up to two results per word.
module vfsp_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_fire,
	input  logic [7:0]     data_byte,
	input  logic           buffer_end,
	output vfsp_pkg::push_t push
);
	import vfsp_pkg::*;

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   end_s1;

	phase_t                 phase_q, phase_n;
	logic [63:0]            acc_q, acc_n, acc_or;
	logic [3:0]             gc_q, gc_n;
	logic [4:0]             field_q, field_n;
	logic [2:0]             type_q, type_n;
	logic [LENGTH_BITS-1:0] left_q, left_n;
	logic [6:0]             shift_prod;
	logic                   too_big;
	result_t                r0, r1;
	logic [1:0]             n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= PH_TAG;
			acc_q    <= '0;
			gc_q     <= '0;
			field_q  <= '0;
			type_q   <= '0;
			left_q   <= '0;
		end else begin
			valid_s1 <= in_fire;
			phase_q  <= phase_n;
			acc_q    <= acc_n;
			gc_q     <= gc_n;
			field_q  <= field_n;
			type_q   <= type_n;
			left_q   <= left_n;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= data_byte;
			end_s1  <= buffer_end;
		end
	end

	// Shift of the next seven-bit group is 7 * group count; beyond bit 63 it falls away.
	assign shift_prod = {gc_q, 3'b000} - {3'b000, gc_q};
	assign acc_or     = acc_q | ({57'b0, byte_s1[6:0]} << shift_prod[5:0]);
	assign too_big    = |(acc_or >> LENGTH_BITS);

	always_comb begin
		phase_n = phase_q;
		acc_n   = acc_q;
		gc_n    = gc_q;
		field_n = field_q;
		type_n  = type_q;
		left_n  = left_q;
		n       = 2'd0;
		r0      = '0;
		r1      = '0;
		if (valid_s1) begin
			case (phase_q)
				PH_DROP: begin
					if (end_s1)
						phase_n = PH_TAG;
				end
				PH_VALUE, PH_LENGTH: begin
					if (gc_q >= 4'(MAX_GROUPS)) begin
						r0 = make_result(KIND_ERROR, field_q, type_q, '0, '0, '0, 1'b0,
							ERR_VARINT_LONG);
						n = 2'd1;
						phase_n = end_s1 ? PH_TAG : PH_DROP;
					end else begin
						acc_n = acc_or;
						gc_n  = gc_q + 4'd1;
						if (byte_s1[7]) begin
							if (end_s1) begin
								r0 = make_result(KIND_ERROR, field_q, type_q, '0, '0, '0,
									1'b0, ERR_VARINT_TRUNC);
								n = 2'd1;
								phase_n = PH_TAG;
							end
						end else if (phase_q == PH_VALUE) begin
							r0 = make_result(KIND_INT, field_q, type_q, acc_or, '0, '0,
								1'b0, ERR_NONE);
							n = 2'd1;
							phase_n = PH_TAG;
						end else if (too_big) begin
							r0 = make_result(KIND_ERROR, field_q, type_q, '0, '0, '0, 1'b0,
								ERR_LENGTH_BIG);
							n = 2'd1;
							phase_n = end_s1 ? PH_TAG : PH_DROP;
						end else begin
							r0 = make_result(KIND_HEADER, field_q, type_q, '0, acc_or[31:0],
								'0, 1'b0, ERR_NONE);
							n = 2'd1;
							left_n = acc_or[LENGTH_BITS-1:0];
							if (acc_or == '0) begin
								phase_n = PH_TAG;
							end else if (end_s1) begin
								r1 = make_result(KIND_ERROR, field_q, type_q, '0, '0, '0,
									1'b0, ERR_STRING_TRUNC);
								n = 2'd2;
								phase_n = PH_TAG;
							end else begin
								phase_n = PH_BODY;
							end
						end
					end
				end
				PH_BODY: begin
					r0 = make_result(KIND_BYTE, field_q, type_q, '0, '0, byte_s1,
						left_q == LENGTH_BITS'(1), ERR_NONE);
					n = 2'd1;
					left_n = left_q - LENGTH_BITS'(1);
					if (left_q == LENGTH_BITS'(1)) begin
						phase_n = PH_TAG;
					end else if (end_s1) begin
						r1 = make_result(KIND_ERROR, field_q, type_q, '0, '0, '0, 1'b0,
							ERR_STRING_TRUNC);
						n = 2'd2;
						phase_n = PH_TAG;
					end
				end
				default: begin
					field_n = byte_s1[7:3];
					type_n  = byte_s1[2:0];
					acc_n   = '0;
					gc_n    = '0;
					left_n  = '0;
					if (type_n inside {WT_VARINT, WT_LEN}) begin
						if (end_s1) begin
							r0 = make_result(KIND_ERROR, field_n, type_n, '0, '0, '0, 1'b0,
								ERR_VARINT_TRUNC);
							n = 2'd1;
							phase_n = PH_TAG;
						end else begin
							phase_n = (type_n == WT_VARINT) ? PH_VALUE : PH_LENGTH;
						end
					end else begin
						r0 = make_result(KIND_ERROR, field_n, type_n, '0, '0, '0, 1'b0,
							ERR_BAD_TYPE);
						n = 2'd1;
						phase_n = end_s1 ? PH_TAG : PH_DROP;
					end
				end
			endcase
		end
		if (n == 2'd1)
			r0.last_of_run = 1'b1;
		if (n == 2'd2)
			r1.last_of_run = 1'b1;
	end

	assign push.n  = n;
	assign push.r0 = r0;
	assign push.r1 = r1;

endmodule

/* design/vfsp_result_fifo.sv */
// Result queue: takes up to two results per cycle, hands them out one at a time, in order.
// Depends on vfsp_pkg.
module vfsp_result_fifo (
	input  logic                        clk,
	input  logic                        arst_n,
	input  vfsp_pkg::push_t             push,
	input  logic                        out_stall,
	output logic                        out_valid,
	output vfsp_pkg::result_t           head,
	output logic [vfsp_pkg::QCNT_W-1:0] count
);
	import vfsp_pkg::*;

	result_t             mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_q, rd_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                pop;

	assign pop       = (cnt_q != '0) && !out_stall;
	assign out_valid = cnt_q != '0;
	assign head      = mem[rd_q];
	assign count     = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QPTR_W'(push.n);
			rd_q  <= rd_q + QPTR_W'(pop);
			cnt_q <= cnt_q + QCNT_W'(push.n) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.n != 2'd0)
			mem[wr_q] <= push.r0;
		if (push.n == 2'd2)
			mem[wr_q + QPTR_W'(1)] <= push.r1;
	end

endmodule

/* design/varint_field_stream_parser.sv */
// Tagged-field byte stream parser. One encoded byte is accepted per clock while
// in_stall is low: the byte is registered, parsed against the field state in the
// next cycle and its results land in a four-entry result queue, so the first
// result reaches the outputs once it has passed the byte register and the queue.
// A byte yields at most two results and the queue drains one per cycle while
// out_stall is low; in_stall rises when the queue, together with the results of
// the byte in flight, holds more than two entries. That comes from output
// stalls, and also from bytes with two results: a run of those is held to the
// pace of the output even with the output free. Depends on vfsp_pkg,
// vfsp_parser and vfsp_result_fifo.
module varint_field_stream_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	input  logic               buffer_end,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         kind,
	output logic [4:0]         field_id,
	output logic [2:0]         wire_type,
	output logic [63:0]        raw_value,
	output logic signed [63:0] zigzag_value,
	output logic [31:0]        string_length,
	output logic [7:0]         body_byte,
	output logic               body_last,
	output logic [2:0]         error_code,
	output logic               last_of_run
);
	import vfsp_pkg::*;

	push_t              push;
	result_t            head;
	logic [QCNT_W-1:0]  count;
	logic [QCNT_W:0]    pending;
	logic               in_fire;

	// Room is kept for two results of the next word on top of those already due.
	assign pending  = {1'b0, count} + (QCNT_W + 1)'(push.n);
	assign in_stall = pending > (QCNT_W + 1)'(QUEUE_DEPTH - 2);
	assign in_fire  = in_valid && !in_stall;

	vfsp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_fire    (in_fire),
		.data_byte  (data_byte),
		.buffer_end (buffer_end),
		.push       (push)
	);

	vfsp_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.head      (head),
		.count     (count)
	);

	assign kind          = head.kind;
	assign field_id      = head.field_id;
	assign wire_type     = head.wire_type;
	assign raw_value     = head.raw_value;
	assign zigzag_value  = head.zigzag_value;
	assign string_length = head.string_length;
	assign body_byte     = head.body_byte;
	assign body_last     = head.body_last;
	assign error_code    = head.error_code;
	assign last_of_run   = head.last_of_run;

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending <= (QCNT_W + 1)'(QUEUE_DEPTH))
		else $error("result queue overflow");

	a_error_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ERROR |-> last_of_run)
		else $error("error result not last of its run");

	a_last_only_on_body: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_BYTE |-> !body_last)
		else $error("body_last set on a result that is not a body word");

endmodule

/* tb/varint_field_stream_parser_test.sv */
// Self-checking testbench for varint_field_stream_parser: encoded buffers go in a byte at a time,
// and a scoreboard class predicts the field results and compares them as they come out.
// Depends on vfsp_pkg and the parser RTL only.
`timescale 1ns / 1ps

import vfsp_pkg::*;

class field_scoreboard;
	phase_t      phase;
	logic [63:0] acc;
	int unsigned groups;
	logic [4:0]  cur_field;
	logic [2:0]  cur_type;
	logic [63:0] left;
	result_t     pending[$];
	int          errors;
	int          parsed;

	function new();
		phase     = PH_TAG;
		acc       = '0;
		groups    = 0;
		cur_field = '0;
		cur_type  = '0;
		left      = '0;
		errors    = 0;
		parsed    = 0;
	endfunction

	function result_t make(kind_t k, logic [63:0] raw, logic [31:0] len, logic [7:0] b,
			logic last, err_t e);
		result_t r;
		r.kind          = k;
		r.field_id      = cur_field;
		r.wire_type     = cur_type;
		r.raw_value     = raw;
		r.zigzag_value  = (raw >> 1) ^ (64'd0 - {63'd0, raw[0]});
		r.string_length = len;
		r.body_byte     = b;
		r.body_last     = last;
		r.error_code    = e;
		r.last_of_run   = 1'b0;
		return r;
	endfunction

	// Work out the results of one accepted input word.
	function void note_byte(logic [7:0] b, logic last_in);
		result_t batch[$];
		parsed++;
		if (phase == PH_DROP) begin
			if (last_in)
				phase = PH_TAG;
			return;
		end
		if (phase == PH_VALUE || phase == PH_LENGTH) begin
			if (groups >= MAX_GROUPS) begin
				batch.push_back(make(KIND_ERROR, '0, '0, '0, 1'b0, ERR_VARINT_LONG));
				phase = last_in ? PH_TAG : PH_DROP;
			end else begin
				// In the tenth group only the lowest payload bit survives the shift.
				acc = acc | ({57'd0, b[6:0]} << (7 * groups));
				groups++;
				if (b[7]) begin
					if (last_in) begin
						batch.push_back(make(KIND_ERROR, '0, '0, '0, 1'b0, ERR_VARINT_TRUNC));
						phase = PH_TAG;
					end
				end else if (phase == PH_VALUE) begin
					batch.push_back(make(KIND_INT, acc, '0, '0, 1'b0, ERR_NONE));
					phase = PH_TAG;
				end else if ((acc >> LENGTH_BITS) != 0) begin
					batch.push_back(make(KIND_ERROR, '0, '0, '0, 1'b0, ERR_LENGTH_BIG));
					phase = last_in ? PH_TAG : PH_DROP;
				end else begin
					batch.push_back(make(KIND_HEADER, '0, acc[31:0], '0, 1'b0, ERR_NONE));
					left = acc;
					if (left == 0) begin
						phase = PH_TAG;
					end else if (last_in) begin
						batch.push_back(make(KIND_ERROR, '0, '0, '0, 1'b0, ERR_STRING_TRUNC));
						phase = PH_TAG;
					end else begin
						phase = PH_BODY;
					end
				end
			end
		end else if (phase == PH_BODY) begin
			batch.push_back(make(KIND_BYTE, '0, '0, b, left == 1, ERR_NONE));
			left--;
			if (left == 0) begin
				phase = PH_TAG;
			end else if (last_in) begin
				batch.push_back(make(KIND_ERROR, '0, '0, '0, 1'b0, ERR_STRING_TRUNC));
				phase = PH_TAG;
			end
		end else begin
			cur_field = b[7:3];
			cur_type  = b[2:0];
			acc       = '0;
			groups    = 0;
			left      = '0;
			if (cur_type == WT_VARINT || cur_type == WT_LEN) begin
				if (last_in)
					batch.push_back(make(KIND_ERROR, '0, '0, '0, 1'b0, ERR_VARINT_TRUNC));
				else
					phase = (cur_type == WT_VARINT) ? PH_VALUE : PH_LENGTH;
			end else begin
				batch.push_back(make(KIND_ERROR, '0, '0, '0, 1'b0, ERR_BAD_TYPE));
				phase = last_in ? PH_TAG : PH_DROP;
			end
		end
		if (batch.size() > 0)
			batch[batch.size() - 1].last_of_run = 1'b1;
		foreach (batch[i])
			pending.push_back(batch[i]);
	endfunction

	function void compare(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	function void check_result(result_t got);
		result_t want;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result, kind %0d field %0d", $time, got.kind,
				got.field_id);
			errors++;
			return;
		end
		want = pending.pop_front();
		compare("kind", want.kind, got.kind);
		compare("field_id", want.field_id, got.field_id);
		compare("wire_type", want.wire_type, got.wire_type);
		compare("raw_value", want.raw_value, got.raw_value);
		compare("zigzag_value", want.zigzag_value, got.zigzag_value);
		compare("string_length", want.string_length, got.string_length);
		compare("body_byte", want.body_byte, got.body_byte);
		compare("body_last", want.body_last, got.body_last);
		compare("error_code", want.error_code, got.error_code);
		compare("last_of_run", want.last_of_run, got.last_of_run);
	endfunction

	function void report_leftover();
		foreach (pending[i]) begin
			$display("%0t: result never arrived, expected kind %0d field %0d", $time,
				pending[i].kind, pending[i].field_id);
			errors++;
		end
	endfunction
endclass

module varint_field_stream_parser_test;
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         data_byte = '0;
	logic               buffer_end = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         kind;
	logic [4:0]         field_id;
	logic [2:0]         wire_type;
	logic [63:0]        raw_value;
	logic signed [63:0] zigzag_value;
	logic [31:0]        string_length;
	logic [7:0]         body_byte;
	logic               body_last;
	logic [2:0]         error_code;
	logic               last_of_run;

	field_scoreboard fields = new();
	bit              idle_on = 1'b1;
	bit              gaps_on = 1'b1;
	logic [7:0]      buf_bytes[$];
	result_t         got;

	varint_field_stream_parser u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .buffer_end(buffer_end),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .field_id(field_id), .wire_type(wire_type),
		.raw_value(raw_value), .zigzag_value(zigzag_value),
		.string_length(string_length), .body_byte(body_byte), .body_last(body_last),
		.error_code(error_code), .last_of_run(last_of_run)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("varint_field_stream_parser_test failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				fields.note_byte(data_byte, buffer_end);
			if (out_valid && !out_stall) begin
				got.kind          = kind_t'(kind);
				got.field_id      = field_id;
				got.wire_type     = wire_type;
				got.raw_value     = raw_value;
				got.zigzag_value  = zigzag_value;
				got.string_length = string_length;
				got.body_byte     = body_byte;
				got.body_last     = body_last;
				got.error_code    = err_t'(error_code);
				got.last_of_run   = last_of_run;
				fields.check_result(got);
			end
		end
	end

	// Output back-pressure, while idle_on is set, mixes random stall bursts and free-running stretches.
	initial begin
		int  run;
		bit  stalling;
		run      = 0;
		stalling = 1'b0;
		forever begin
			@(negedge clk);
			if (run == 0) begin
				stalling = 1'($urandom_range(0, 1));
				run      = stalling ? $urandom_range(1, 15) : $urandom_range(1, 40);
			end
			run--;
			out_stall <= idle_on && stalling;
		end
	end

	task automatic send_byte(logic [7:0] b, logic last_in);
		int gap;
		gap = 0;
		if (idle_on && gaps_on && $urandom_range(0, 4) == 0)
			gap = $urandom_range(1, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		data_byte  <= b;
		buffer_end <= last_in;
		in_valid   <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Appends a varint of at least the given number of groups; beyond ten groups the
	// extra ones are zero padding, all but the last with the continuation bit set.
	function automatic void put_varint(logic [63:0] v, int total);
		int         n;
		logic [7:0] b;
		n = 1;
		while (n < 10 && (v >> (7 * n)) != 0)
			n++;
		if (total > n)
			n = total;
		for (int i = 0; i < n; i++) begin
			b = (i < 10) ? {1'b0, 7'((v >> (7 * i)) & 64'h7f)} : 8'h00;
			if (i < n - 1)
				b[7] = 1'b1;
			buf_bytes.push_back(b);
		end
	endfunction

	// Appends one field, well formed or deliberately broken; returns 1 when the buffer
	// has to end right after it.
	function automatic bit add_field();
		logic [4:0]  fld;
		logic [2:0]  wt;
		logic [63:0] v;
		int          pad;
		int          len;
		fld = 5'($urandom_range(0, 31));
		pad = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : 0;
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5, 6, 7: begin
				buf_bytes.push_back({fld, WT_VARINT});
				case ($urandom_range(0, 3))
					0: v = 64'($urandom_range(0, 127));
					1: v = {$urandom, $urandom} >> $urandom_range(0, 63);
					2: v = '1;
					default: v = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
				endcase
				put_varint(v, pad);
			end
			8, 9, 10, 11, 12, 13, 14: begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
				buf_bytes.push_back({fld, WT_LEN});
				put_varint(64'(len), pad);
				repeat (len) buf_bytes.push_back(8'($urandom_range(0, 255)));
			end
			15: begin
				wt = 3'($urandom_range(1, 7));
				if (wt == WT_LEN)
					wt = 3'd3;
				buf_bytes.push_back({fld, wt});
			end
			16: begin
				buf_bytes.push_back({fld, $urandom_range(0, 1) ? WT_LEN : WT_VARINT});
				repeat (10) buf_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
				buf_bytes.push_back(8'($urandom_range(0, 255)));
			end
			17: begin
				buf_bytes.push_back({fld, WT_LEN});
				if ($urandom_range(0, 3) == 0)
					v = 64'h1_0000_0000;
				else
					v = {$urandom, $urandom} | (64'd1 << $urandom_range(32, 63));
				put_varint(v, pad);
			end
			18: begin
				// A long body cannot be sent whole, so it is always cut by the buffer end.
				buf_bytes.push_back({fld, WT_LEN});
				v = ($urandom_range(0, 3) == 0) ? 64'hffff_ffff : {32'd0, $urandom | 32'h100};
				put_varint(v, pad);
				repeat ($urandom_range(0, 5)) buf_bytes.push_back(8'($urandom_range(0, 255)));
				return 1'b1;
			end
			default: begin
				repeat ($urandom_range(1, 6)) buf_bytes.push_back(8'($urandom_range(0, 255)));
			end
		endcase
		return 1'b0;
	endfunction

	task automatic send_buffer();
		int keep;
		buf_bytes.delete();
		for (int i = $urandom_range(1, 4); i > 0; i--) begin
			if (add_field())
				break;
		end
		if ($urandom_range(0, 5) == 0) begin
			keep = $urandom_range(1, buf_bytes.size());
			while (buf_bytes.size() > keep)
				void'(buf_bytes.pop_back());
		end
		foreach (buf_bytes[i])
			send_byte(buf_bytes[i], i == buf_bytes.size() - 1);
	endtask

	initial begin
		int waited;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words: zero integer, empty and short strings, bad type at the buffer
		// end, tag at the buffer end, body cut by the buffer end, length too big then drop.
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h0a, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h12, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'haa, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'h1b, 1'b1);
		send_byte(8'hf8, 1'b1);
		send_byte(8'h12, 1'b0);
		send_byte(8'h03, 1'b0);
		send_byte(8'hff, 1'b1);
		send_byte(8'h12, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h10, 1'b0);
		send_byte(8'h33, 1'b1);

		while (fields.parsed < 1620) begin
			gaps_on = $urandom_range(0, 2) != 0;
			if (fields.parsed > 1400)
				idle_on = 1'b0;
			send_buffer();
		end
		in_valid <= 1'b0;

		waited = 0;
		while (fields.pending.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		fields.report_leftover();
		if (fields.errors == 0)
			$display("varint_field_stream_parser_test passed");
		else
			$display("varint_field_stream_parser_test failed");
		$finish;
	end
endmodule

/* varint_field_stream_parser.f */
design/vfsp_pkg.sv
design/vfsp_parser.sv
design/vfsp_result_fifo.sv
design/varint_field_stream_parser.sv
tb/varint_field_stream_parser_test.sv
